@@ sv/xls_pkg.sv @@
package xls_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  typedef enum logic [3:0] {
    ACT_TEST = 4'd0,
    ACT_AND  = 4'd1,
    ACT_XOR  = 4'd2,
    ACT_OR   = 4'd3,
    ACT_NOT  = 4'd4,
    ACT_SAR  = 4'd5,
    ACT_SHL  = 4'd6,
    ACT_SHR  = 4'd7,
    ACT_ROL  = 4'd8,
    ACT_ROR  = 4'd9
  } action_t;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              wr;
    logic              cf;
    logic              cfu;
    logic              of;
    logic              ofu;
    logic              zf;
    logic              sf;
    logic              zsu;
  } alu_result_t;

endpackage

@@ sv/x86_logic_shift_unit.sv @@
// Result word passes the input register, single-pass ALU logic with barrel
// shifter/rotator, and the output register before it is valid at the outputs.
// Throughput: one word per cycle; input stalls only while both registers hold
// words and out_ready is low.
// Reset (rst, synchronous, active high) empties both stages; payload is not reset.
module x86_logic_shift_unit import xls_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        action,
  input  logic [1:0]        operand_size,
  input  logic [DATA_W-1:0] dest_value,
  input  logic [DATA_W-1:0] source_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] result_value,
  output logic              write_result,
  output logic              carry_flag,
  output logic              carry_update,
  output logic              overflow_flag,
  output logic              overflow_update,
  output logic              zero_flag,
  output logic              sign_flag,
  output logic              zero_sign_update
);

  logic              stage_valid;
  logic [3:0]        stage_action;
  logic [1:0]        stage_size;
  logic [DATA_W-1:0] stage_dest;
  logic [DATA_W-1:0] stage_source;
  logic              out_adv;
  alu_result_t       alu_res;

  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !stage_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_action <= action;
      stage_size   <= operand_size;
      stage_dest   <= dest_value;
      stage_source <= source_value;
    end
  end

  xls_alu u_alu (
    .action       (stage_action),
    .operand_size (stage_size),
    .dest_value   (stage_dest),
    .source_value (stage_source),
    .res          (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && stage_valid) begin
      result_value     <= alu_res.value;
      write_result     <= alu_res.wr;
      carry_flag       <= alu_res.cf;
      carry_update     <= alu_res.cfu;
      overflow_flag    <= alu_res.of;
      overflow_update  <= alu_res.ofu;
      zero_flag        <= alu_res.zf;
      sign_flag        <= alu_res.sf;
      zero_sign_update <= alu_res.zsu;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid && out_valid && !out_ready))
    else $error("input stalled while pipeline not full");

  a_flags_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !zero_sign_update) |-> (!zero_flag && !sign_flag))
    else $error("ZF/SF set without update enable");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_sign_update) |-> (zero_flag == (result_value == '0)))
    else $error("ZF disagrees with result");

  a_test_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_sign_update && !write_result) |-> overflow_update)
    else $error("result dropped for non-test operation");

  a_cf_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !carry_update) |-> !carry_flag)
    else $error("CF set without update enable");
`endif

endmodule

@@ sv/xls_alu.sv @@
module xls_alu import xls_pkg::*; (
  input  logic [3:0]        action,
  input  logic [1:0]        operand_size,
  input  logic [DATA_W-1:0] dest_value,
  input  logic [DATA_W-1:0] source_value,
  output alu_result_t       res
);

  logic [DATA_W-1:0]   mask;
  logic [DATA_W-1:0]   d;
  logic [DATA_W-1:0]   s;
  logic [CNT_W-1:0]    cnt;
  logic                d_sign;
  logic [DATA_W-1:0]   sext;
  logic [DATA_W-1:0]   sar_val;
  logic [DATA_W-1:0]   rep;
  logic [2*DATA_W-1:0] rol_wide;
  logic [2*DATA_W-1:0] ror_wide;
  logic [DATA_W-1:0]   r;
  logic                r_sign;

  always_comb begin
    case (operand_size)
      SIZE_BYTE: begin
        mask   = 32'h0000_00ff;
        d_sign = dest_value[7];
        rep    = {4{dest_value[7:0]}};
      end
      SIZE_WORD: begin
        mask   = 32'h0000_ffff;
        d_sign = dest_value[15];
        rep    = {2{dest_value[15:0]}};
      end
      default: begin
        mask   = '1;
        d_sign = dest_value[DATA_W-1];
        rep    = dest_value;
      end
    endcase
  end

  assign d   = dest_value & mask;
  assign s   = source_value & mask;
  assign cnt = source_value[CNT_W-1:0];

  // sign-extend from operand width, then shift at full width
  assign sext    = d_sign ? (d | ~mask) : d;
  assign sar_val = DATA_W'($signed(sext) >>> cnt) & mask;

  // replicated operand is periodic in the width, so a full-width rotate is exact
  assign rol_wide = {rep, rep} << cnt;
  assign ror_wide = {rep, rep} >> cnt;

  always_comb begin
    res = '0;
    r   = '0;
    case (action)
      ACT_TEST: begin
        r = d & s;
        res.cfu = 1'b1; res.ofu = 1'b1; res.zsu = 1'b1;
      end
      ACT_AND: begin
        r = d & s;
        res.wr = 1'b1; res.cfu = 1'b1; res.ofu = 1'b1; res.zsu = 1'b1;
      end
      ACT_XOR: begin
        r = d ^ s;
        res.wr = 1'b1; res.cfu = 1'b1; res.ofu = 1'b1; res.zsu = 1'b1;
      end
      ACT_OR: begin
        r = d | s;
        res.wr = 1'b1; res.cfu = 1'b1; res.ofu = 1'b1; res.zsu = 1'b1;
      end
      ACT_NOT: begin
        r = ~d & mask;
        res.wr = 1'b1;
      end
      ACT_SAR: begin
        r = sar_val;
        res.wr = 1'b1; res.zsu = 1'b1;
      end
      ACT_SHL: begin
        r = (d << cnt) & mask;
        res.wr = 1'b1; res.zsu = 1'b1;
      end
      ACT_SHR: begin
        r = d >> cnt;
        res.wr = 1'b1; res.zsu = 1'b1;
      end
      ACT_ROL: begin
        r = rol_wide[2*DATA_W-1:DATA_W] & mask;
        res.wr = 1'b1; res.zsu = 1'b1;
        res.cfu = (cnt != '0);
      end
      ACT_ROR: begin
        r = ror_wide[DATA_W-1:0] & mask;
        res.wr = 1'b1; res.zsu = 1'b1;
        res.cfu = (cnt != '0);
      end
      default: begin
        r = '0;
      end
    endcase
    case (operand_size)
      SIZE_BYTE: r_sign = r[7];
      SIZE_WORD: r_sign = r[15];
      default:   r_sign = r[DATA_W-1];
    endcase
    res.value = r;
    if (res.zsu) begin
      res.zf = (r == '0);
      res.sf = r_sign;
    end
    if (res.cfu && action == ACT_ROL) begin
      res.cf = r[0];
    end else if (res.cfu && action == ACT_ROR) begin
      res.cf = r_sign;
    end
  end

endmodule
